@@ src/tam_pkg.sv @@
// Shared types, constants and the acceptance table for the TSP annealing move engine.
// No dependencies.
package tam_pkg;

  localparam int MAX_VERTICES    = 128;
  localparam int CITY_BITS       = $clog2(MAX_VERTICES);
  localparam int VTX_BITS        = $clog2(MAX_VERTICES + 1);
  localparam int DIST_ADDR_BITS  = 2 * CITY_BITS;
  localparam int DISTANCE_BITS   = 20;
  localparam int COST_BITS       = 27;
  localparam int TEMP_BITS       = 24;
  localparam int STEP_BITS       = 16;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);

  localparam logic [COST_BITS-1:0] COST_MAX    = {COST_BITS{1'b1}};
  localparam logic [31:0]          EXP_STEP_MUL = 32'd4162825044;

  localparam logic [1:0] CMD_LOAD_DIST = 2'd0;
  localparam logic [1:0] CMD_LOAD_STOP = 2'd1;
  localparam logic [1:0] CMD_RESTART   = 2'd2;
  localparam logic [1:0] CMD_ANNEAL    = 2'd3;

  localparam logic [2:0] OUT_LOADED   = 3'd0;
  localparam logic [2:0] OUT_IMPROVED = 3'd1;
  localparam logic [2:0] OUT_ACCEPTED = 3'd2;
  localparam logic [2:0] OUT_REJECTED = 3'd3;
  localparam logic [2:0] OUT_INVALID  = 3'd4;
  localparam logic [2:0] OUT_FINISHED = 3'd5;

  localparam logic [2:0] CFG_NUM_VERTICES = 3'd0;
  localparam logic [2:0] CFG_ENDPOINT_PCT = 3'd1;
  localparam logic [2:0] CFG_PERTURB_MODE = 3'd2;
  localparam logic [2:0] CFG_START_TEMP   = 3'd3;
  localparam logic [2:0] CFG_FINAL_TEMP   = 3'd4;
  localparam logic [2:0] CFG_COOLING      = 3'd5;
  localparam logic [2:0] CFG_ITER_START   = 3'd6;
  localparam logic [2:0] CFG_ITER_SHRINK  = 3'd7;

  // move description seen by the tour walker
  typedef struct packed {
    logic                prop;
    logic                endpoint;
    logic                swap;
    logic [VTX_BITS-1:0] c1;
    logic [VTX_BITS-1:0] c2;
    logic [VTX_BITS-1:0] pick;
    logic [VTX_BITS-1:0] n;
  } walk_cfg_t;

  typedef logic [15:0] exp_tab_t [EXP_TABLE_DEPTH];

  // exp(-k/32) in Q0.16, rounded, saturated
  function automatic exp_tab_t exp_table();
    exp_tab_t    tab;
    logic [95:0] e;
    logic [95:0] v;
    e = 96'd1 << 32;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      v = (e + 96'd32768) >> 16;
      tab[k] = (v > 96'd65535) ? 16'hFFFF : v[15:0];
      e = (e * {64'd0, EXP_STEP_MUL} + 96'h8000_0000) >> 32;
    end
    return tab;
  endfunction

endpackage

@@ src/tsp_annealing_move_engine.sv @@
// Top level of the TSP annealing move engine: sequencer, schedule, memories.
// Depends on tam_pkg, tam_ram, tam_walker, tam_div.
//
// Usage: configuration registers are written through cfg_we / cfg_index / cfg_data
// while the block is idle. Input items arrive on in_valid / in_ready, each with a
// command: load a distance entry, load a tour stop, restart the schedule, or run one
// annealing step from the random draws carried in the item. Every item yields exactly
// one result item on out_valid / out_ready.
// Every item walks the kept tour once; an annealing step with a valid move also walks
// the candidate tour, and copies it into the kept tour when it is kept (n cities in use).
// The tour walker reads one tour stop and one distance per cycle.
// One item is in work at a time; in_ready is high only between items.
// The result sits in an output register; the next item is taken while it waits, and
// a stalled receiver holds the block at its result stage until the register frees.
// Reset clears the schedule, cost and configuration to their defaults; the distance
// and tour memories hold nothing defined until loaded.
module tsp_annealing_move_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [6:0]  row,
  input  logic [6:0]  column,
  input  logic [19:0] distance,
  input  logic [7:0]  stop_index,
  input  logic [7:0]  stop_vertex,
  input  logic [6:0]  select_draw,
  input  logic [7:0]  vertex_pick,
  input  logic [6:0]  first_cut,
  input  logic [7:0]  second_cut,
  input  logic [6:0]  accept_draw,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  outcome,
  output logic [26:0] current_cost,
  output logic [26:0] candidate_cost,
  output logic [23:0] temperature_now,
  output logic        schedule_done
);

  localparam int VB = tam_pkg::VTX_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_KPASS = 4'd2;
  localparam logic [3:0] S_PPASS = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_COPY  = 4'd5;
  localparam logic [3:0] S_SCHED = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  localparam tam_pkg::exp_tab_t EXP_TAB = tam_pkg::exp_table();

  logic [3:0]  state;

  logic [7:0]  num_vertices;
  logic [6:0]  endpoint_percent;
  logic        perturb_mode;
  logic [23:0] start_temperature, final_temperature;
  logic [7:0]  cooling_factor, iteration_shrink;
  logic [15:0] iterations_start;

  logic [1:0]  cmd;
  logic [6:0]  row_l, col_l, sel_l, draw_l, c1_l;
  logic [19:0] dist_l;
  logic [7:0]  sidx_l, svtx_l, pick_l, c2_l;

  logic [26:0] kept_cost, cand;
  logic [23:0] temperature;
  logic [15:0] level_step, steps_per_level;
  logic        finished;
  logic [2:0]  outc;

  logic [VB-1:0] n;
  logic          use_ep, cuts_ok, anneal_go;

  tam_pkg::walk_cfg_t                 wcfg;
  logic                               walk_start, walk_done, walk_ok;
  logic [26:0]                        walk_cost;
  logic [VB-1:0]                      tour_raddr, tour_rdata;
  logic [tam_pkg::DIST_ADDR_BITS-1:0] dist_raddr;
  logic [19:0]                        dist_rdata;
  logic                               dist_we;
  logic                               prop_we;
  logic [VB-1:0]                      prop_waddr, prop_wdata, prop_rdata;

  logic          kept_we;
  logic [VB-1:0] kept_waddr, kept_wdata;

  logic          cp_run, cp_v, cp_last;
  logic [VB-1:0] cp_cnt, cp_addr;

  logic        div_start, div_done, div_over;
  logic [7:0]  div_quot;
  logic [15:0] prob;
  logic [23:0] lhs, rhs;
  logic        take_ch;

  logic [31:0] temp_prod;
  logic [23:0] step_prod;
  logic [16:0] lvl_next;

  always_comb begin
    if (num_vertices < 8'd3) begin
      n = VB'(3);
    end else if (num_vertices > 8'(tam_pkg::MAX_VERTICES)) begin
      n = VB'(tam_pkg::MAX_VERTICES);
    end else begin
      n = VB'(num_vertices);
    end
  end

  assign use_ep    = sel_l < endpoint_percent;
  assign cuts_ok   = (c1_l >= 7'd2) && ({1'b0, c1_l} < c2_l) && (c2_l <= n);
  assign anneal_go = (cmd == tam_pkg::CMD_ANNEAL) && !finished;

  assign wcfg.prop     = (state == S_PPASS);
  assign wcfg.endpoint = use_ep;
  assign wcfg.swap     = perturb_mode;
  assign wcfg.c1       = {1'b0, c1_l};
  assign wcfg.c2       = c2_l;
  assign wcfg.pick     = pick_l;
  assign wcfg.n        = n;

  assign walk_start = (state == S_LOAD) ||
                      (state == S_KPASS && walk_done && anneal_go && (use_ep || cuts_ok));

  assign in_ready = (state == S_IDLE);
  assign dist_we  = (state == S_LOAD) && (cmd == tam_pkg::CMD_LOAD_DIST);

  always_comb begin
    kept_we    = cp_v;
    kept_waddr = cp_addr;
    kept_wdata = prop_rdata;
    if (state == S_LOAD && cmd == tam_pkg::CMD_LOAD_STOP &&
        sidx_l <= 8'(tam_pkg::MAX_VERTICES)) begin
      kept_we    = 1'b1;
      kept_waddr = sidx_l;
      kept_wdata = svtx_l;
    end
  end

  assign div_start = (state == S_PPASS) && walk_done && walk_ok && !(walk_cost < kept_cost);
  assign prob      = div_over ? 16'd0 : EXP_TAB[div_quot];
  assign lhs       = {1'b0, draw_l, 16'h0000};
  assign rhs       = 24'(prob) * 24'd100;
  assign take_ch   = lhs < rhs;

  assign temp_prod = temperature * {24'd0, cooling_factor};
  assign step_prod = steps_per_level * {16'd0, iteration_shrink};
  assign lvl_next  = {1'b0, level_step} + 17'd1;

  tam_ram #(.WIDTH(20), .DEPTH(tam_pkg::MAX_VERTICES * tam_pkg::MAX_VERTICES),
            .ADDR_BITS(tam_pkg::DIST_ADDR_BITS)) u_dist (
    .clk(clk), .we(dist_we), .waddr({row_l, col_l}), .wdata(dist_l),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  tam_ram #(.WIDTH(VB), .DEPTH(tam_pkg::MAX_VERTICES + 1), .ADDR_BITS(VB)) u_kept (
    .clk(clk), .we(kept_we), .waddr(kept_waddr), .wdata(kept_wdata),
    .raddr(tour_raddr), .rdata(tour_rdata)
  );

  tam_ram #(.WIDTH(VB), .DEPTH(tam_pkg::MAX_VERTICES + 1), .ADDR_BITS(VB)) u_prop (
    .clk(clk), .we(prop_we), .waddr(prop_waddr), .wdata(prop_wdata),
    .raddr(cp_cnt), .rdata(prop_rdata)
  );

  tam_walker u_walk (
    .clk(clk), .rst(rst), .start(walk_start), .cfg(wcfg),
    .tour_raddr(tour_raddr), .tour_rdata(tour_rdata),
    .dist_raddr(dist_raddr), .dist_rdata(dist_rdata),
    .prop_we(prop_we), .prop_waddr(prop_waddr), .prop_wdata(prop_wdata),
    .done(walk_done), .cost(walk_cost), .path_ok(walk_ok)
  );

  tam_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .delta(walk_cost - kept_cost), .temp(temperature),
    .done(div_done), .over(div_over), .quot(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices      <= 8'd7;
      endpoint_percent  <= 7'd50;
      perturb_mode      <= 1'b0;
      start_temperature <= 24'd35840;
      final_temperature <= 24'd2560;
      cooling_factor    <= 8'd128;
      iterations_start  <= 16'd30;
      iteration_shrink  <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        tam_pkg::CFG_NUM_VERTICES: num_vertices      <= cfg_data[7:0];
        tam_pkg::CFG_ENDPOINT_PCT: endpoint_percent  <= cfg_data[6:0];
        tam_pkg::CFG_PERTURB_MODE: perturb_mode      <= cfg_data[0];
        tam_pkg::CFG_START_TEMP:   start_temperature <= cfg_data;
        tam_pkg::CFG_FINAL_TEMP:   final_temperature <= cfg_data;
        tam_pkg::CFG_COOLING:      cooling_factor    <= cfg_data[7:0];
        tam_pkg::CFG_ITER_START:   iterations_start  <= cfg_data[15:0];
        tam_pkg::CFG_ITER_SHRINK:  iteration_shrink  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd    <= command;
      row_l  <= row;
      col_l  <= column;
      dist_l <= distance;
      sidx_l <= stop_index;
      svtx_l <= stop_vertex;
      sel_l  <= select_draw;
      pick_l <= vertex_pick;
      c1_l   <= first_cut;
      c2_l   <= second_cut;
      draw_l <= accept_draw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      kept_cost       <= '0;
      temperature     <= 24'd35840;
      steps_per_level <= 16'd30;
      level_step      <= '0;
      finished        <= 1'b0;
      cp_run          <= 1'b0;
      cp_v            <= 1'b0;
      cp_cnt          <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      cp_v <= cp_run;
      if (cp_run) begin
        cp_addr <= cp_cnt;
        cp_last <= (cp_cnt == n);
        if (cp_cnt == n) begin
          cp_run <= 1'b0;
        end else begin
          cp_cnt <= cp_cnt + VB'(1);
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cand <= '0;
          outc <= tam_pkg::OUT_LOADED;
          if (cmd == tam_pkg::CMD_RESTART) begin
            temperature     <= start_temperature;
            steps_per_level <= iterations_start;
            level_step      <= '0;
            finished        <= 1'b0;
          end
          if (cmd == tam_pkg::CMD_ANNEAL && finished) begin
            outc <= tam_pkg::OUT_FINISHED;
          end
          state <= S_KPASS;
        end
        S_KPASS: begin
          if (walk_done) begin
            kept_cost <= walk_cost;
            if (!anneal_go) begin
              state <= S_OUT;
            end else if (use_ep || cuts_ok) begin
              state <= S_PPASS;
            end else begin
              outc  <= tam_pkg::OUT_INVALID;
              state <= S_OUT;
            end
          end
        end
        S_PPASS: begin
          if (walk_done) begin
            cand <= walk_cost;
            if (!walk_ok) begin
              outc  <= tam_pkg::OUT_INVALID;
              state <= S_OUT;
            end else if (walk_cost < kept_cost) begin
              outc   <= tam_pkg::OUT_IMPROVED;
              cp_run <= 1'b1;
              cp_cnt <= '0;
              state  <= S_COPY;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (take_ch) begin
              outc   <= tam_pkg::OUT_ACCEPTED;
              cp_run <= 1'b1;
              cp_cnt <= '0;
              state  <= S_COPY;
            end else begin
              outc  <= tam_pkg::OUT_REJECTED;
              state <= S_SCHED;
            end
          end
        end
        S_COPY: begin
          if (cp_v && cp_last) begin
            kept_cost <= cand;
            state     <= S_SCHED;
          end
        end
        S_SCHED: begin
          if (lvl_next >= {1'b0, steps_per_level}) begin
            temperature     <= temp_prod[31:8];
            steps_per_level <= step_prod[23:8];
            level_step      <= '0;
            if (temp_prod[31:8] <= final_temperature) begin
              finished <= 1'b1;
            end
          end else begin
            level_step <= lvl_next[15:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            outcome         <= outc;
            current_cost    <= kept_cost;
            candidate_cost  <= cand;
            temperature_now <= temperature;
            schedule_done   <= finished;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/tam_ram.sv @@
// Simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module tam_ram #(
  parameter int WIDTH     = 8,
  parameter int DEPTH     = 129,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/tam_div.sv @@
// Iterative divider for the acceptance table index: floor(delta*512/T), one bit a cycle.
// Depends on tam_pkg.
module tam_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tam_pkg::COST_BITS-1:0]    delta,
  input  logic [tam_pkg::TEMP_BITS-1:0]    temp,
  output logic                             done,
  output logic                             over,
  output logic [tam_pkg::EXP_IDX_BITS-1:0] quot
);

  localparam int RW = tam_pkg::TEMP_BITS + 1;

  logic                             busy;
  logic                             zero;
  logic [3:0]                       cnt;
  logic [RW-1:0]                    r;
  logic [tam_pkg::TEMP_BITS-1:0]    d;
  logic [tam_pkg::EXP_IDX_BITS-1:0] q;
  logic [RW-1:0]                    rs;

  assign rs   = {r[RW-2:0], 1'b0};
  assign quot = zero ? '0 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        r    <= RW'({delta, 1'b0});
        d    <= temp;
        q    <= '0;
        zero <= (delta == '0);
        over <= (delta != '0) &&
                ({delta, 1'b0} >= (tam_pkg::COST_BITS+1)'(temp));
      end else if (busy) begin
        if (rs >= {1'b0, d}) begin
          r <= rs - {1'b0, d};
          q <= {q[tam_pkg::EXP_IDX_BITS-2:0], 1'b1};
        end else begin
          r <= rs;
          q <= {q[tam_pkg::EXP_IDX_BITS-2:0], 1'b0};
        end
        if (cnt == 4'(tam_pkg::EXP_IDX_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 4'd1;
        end
      end
    end
  end

endmodule

@@ src/tam_walker.sv @@
// Tour walker: streams a tour from RAM, optionally applies a move, sums edge distances.
// Depends on tam_pkg; drives the tour, proposed-tour and distance RAM ports.
module tam_walker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  tam_pkg::walk_cfg_t                 cfg,
  output logic [tam_pkg::VTX_BITS-1:0]       tour_raddr,
  input  logic [tam_pkg::VTX_BITS-1:0]       tour_rdata,
  output logic [tam_pkg::DIST_ADDR_BITS-1:0] dist_raddr,
  input  logic [tam_pkg::DISTANCE_BITS-1:0]  dist_rdata,
  output logic                               prop_we,
  output logic [tam_pkg::VTX_BITS-1:0]       prop_waddr,
  output logic [tam_pkg::VTX_BITS-1:0]       prop_wdata,
  output logic                               done,
  output logic [tam_pkg::COST_BITS-1:0]      cost,
  output logic                               path_ok
);

  localparam int VB = tam_pkg::VTX_BITS;
  localparam int CB = tam_pkg::CITY_BITS;

  logic                          run;
  logic [VB-1:0]                 cnt;
  logic                          s1_v, s1_last;
  logic [VB-1:0]                 s1_pos;
  logic                          s2_v, s2_last, s2_inr;
  logic [VB-1:0]                 prev_v, kept_last, v;
  logic [tam_pkg::COST_BITS:0]   acc;
  logic [VB:0]                   rev_sum;
  logic                          in_rev, a_ok, b_ok;
  logic [VB-1:0]                 am1, bm1;

  assign rev_sum = {1'b0, cfg.c1} + {1'b0, cfg.c2} - (VB+1)'(2) - {1'b0, cnt};
  assign in_rev  = (cnt >= cfg.c1 - VB'(1)) && (cnt < cfg.c2);

  always_comb begin
    tour_raddr = cnt;
    if (cfg.prop && !cfg.endpoint) begin
      if (cfg.swap) begin
        if (cnt == cfg.c2 - VB'(1)) begin
          tour_raddr = cfg.c1 - VB'(1);
        end else if (cnt == cfg.c1 - VB'(1)) begin
          tour_raddr = cfg.c2 - VB'(1);
        end
      end else if (in_rev) begin
        tour_raddr = rev_sum[VB-1:0];
      end
    end
  end

  always_comb begin
    v = tour_rdata;
    if (cfg.prop && cfg.endpoint) begin
      if (s1_pos == '0 || s1_pos == cfg.n) begin
        v = cfg.pick;
      end else if (tour_rdata == cfg.pick) begin
        v = kept_last;
      end
    end
  end

  assign a_ok       = (prev_v != '0) && (prev_v <= cfg.n);
  assign b_ok       = (v != '0) && (v <= cfg.n);
  assign am1        = prev_v - VB'(1);
  assign bm1        = v - VB'(1);
  assign dist_raddr = {am1[CB-1:0], bm1[CB-1:0]};
  assign prop_we    = s1_v && cfg.prop;
  assign prop_waddr = s1_pos;
  assign prop_wdata = v;
  assign cost       = (acc > {1'b0, tam_pkg::COST_MAX}) ? tam_pkg::COST_MAX
                                                         : acc[tam_pkg::COST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= s2_v && s2_last;
      s1_v <= run;
      if (start) begin
        run     <= 1'b1;
        cnt     <= '0;
        acc     <= '0;
        path_ok <= 1'b1;
      end else if (run) begin
        s1_pos  <= cnt;
        s1_last <= (cnt == cfg.n);
        if (cnt == cfg.n) begin
          run <= 1'b0;
        end else begin
          cnt <= cnt + VB'(1);
        end
      end
      s2_v <= s1_v && (s1_pos != '0);
      if (s1_v) begin
        prev_v  <= v;
        s2_last <= s1_last;
        s2_inr  <= a_ok && b_ok;
        if (!cfg.prop && s1_last) begin
          kept_last <= tour_rdata;
        end
      end
      if (s2_v) begin
        if (s2_inr) begin
          acc <= acc + (tam_pkg::COST_BITS+1)'(dist_rdata);
        end
        if (!s2_inr || dist_rdata == '0) begin
          path_ok <= 1'b0;
        end
      end
    end
  end

endmodule

@@ src/tam_checker.sv @@
// Port-level checks for the TSP annealing move engine, bound to the top level.
// Depends on tam_pkg and tsp_annealing_move_engine.
module tam_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  outcome,
  input logic [26:0] current_cost,
  input logic [26:0] candidate_cost,
  input logic        schedule_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(current_cost) && $stable(outcome))
    else $error("result changed while stalled");

  a_finished_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == tam_pkg::OUT_FINISHED |-> schedule_done)
    else $error("finished item without schedule_done");

  a_kept_cost: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == tam_pkg::OUT_IMPROVED || outcome == tam_pkg::OUT_ACCEPTED)
    |-> current_cost == candidate_cost)
    else $error("kept candidate cost mismatch");

  a_no_cand: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome == tam_pkg::OUT_LOADED || outcome == tam_pkg::OUT_FINISHED)
    |-> candidate_cost == '0)
    else $error("candidate cost on non-step item");

  a_improved_lower: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == tam_pkg::OUT_REJECTED |-> candidate_cost >= current_cost)
    else $error("cheaper candidate rejected");

endmodule

bind tsp_annealing_move_engine tam_checker u_tam_checker (.*);
